// ===== rtl/ils_pkg.sv =====
`default_nettype none
package ils_pkg;

  // Position and length width inside the block. It covers every capacity
  // up to 1024 entries, so a length equal to the capacity still fits.
  localparam int POS_W = 11;

  localparam int VALUE_W = 32;

  // Fan-in of one node of the read-out tree.
  localparam int TREE_RADIX = 8;

  typedef enum logic [2:0] {
    MODE_READ   = 3'd0,
    MODE_HEAD   = 3'd1,
    MODE_TAIL   = 3'd2,
    MODE_AT     = 3'd3,
    MODE_DELETE = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] rd_pos;
  } ils_cmd_t;

  // Number of registered levels needed to reduce n leaves to one node.
  function automatic int tree_levels(input int n);
    int c;
    int l;
    c = n;
    l = 0;
    for (int k = 0; k < 32; k++) begin
      if (c > 1) begin
        c = (c + TREE_RADIX - 1) / TREE_RADIX;
        l++;
      end
    end
    if (l == 0) begin
      l = 1;
    end
    return l;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ils_cell.sv =====
`default_nettype none
module ils_cell
  import ils_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic               clk,
  input  wire ils_cmd_t           cmd,
  input  wire logic [VALUE_W-1:0] ins_value,
  input  wire logic [VALUE_W-1:0] left_value,
  input  wire logic [VALUE_W-1:0] right_value,
  output logic      [VALUE_W-1:0] value,
  output logic      [VALUE_W-1:0] leaf
);

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

  logic [VALUE_W-1:0] value_next;

  // Insert: cells above the position take their left neighbor, the cell at
  // the position takes the new value. Delete: cells from the position up
  // take their right neighbor.
  always_comb begin
    value_next = value;
    if (cmd.ins) begin
      if (MY_IDX == cmd.pos) begin
        value_next = ins_value;
      end else if (MY_IDX > cmd.pos) begin
        value_next = left_value;
      end
    end else if (cmd.del && (MY_IDX >= cmd.pos)) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  assign leaf = (cmd.rd_pos == MY_IDX) ? value : '0;

endmodule
`default_nettype wire

// ===== rtl/ils_or_tree.sv =====
`default_nettype none
module ils_or_tree
  import ils_pkg::*;
#(
  parameter int N = 64
) (
  input  wire logic               clk,
  input  wire logic [VALUE_W-1:0] leaf [N],
  output logic      [VALUE_W-1:0] top
);

  localparam int LEVELS = tree_levels(N);

  // Node count of level l; level 0 is the leaves.
  function automatic int lvl_cnt(input int l);
    int c;
    c = N;
    for (int k = 0; k < l; k++) begin
      c = (c + TREE_RADIX - 1) / TREE_RADIX;
    end
    return c;
  endfunction

  // Offset of level l (l >= 1) in the node array.
  function automatic int lvl_base(input int l);
    int b;
    b = 0;
    for (int k = 1; k < l; k++) begin
      b = b + lvl_cnt(k);
    end
    return b;
  endfunction

  localparam int TOTAL = lvl_base(LEVELS + 1);

  logic [VALUE_W-1:0] node [TOTAL];

  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    for (genvar j = 0; j < lvl_cnt(l); j++) begin : g_node
      localparam int CNT_IN = lvl_cnt(l - 1);
      localparam int FAN = (CNT_IN - TREE_RADIX * j < TREE_RADIX) ?
                           (CNT_IN - TREE_RADIX * j) : TREE_RADIX;
      localparam int OUT_IDX = lvl_base(l) + j;

      logic [VALUE_W-1:0] acc;

      if (l == 1) begin : g_from_leaf
        always_comb begin
          acc = '0;
          for (int k = 0; k < FAN; k++) begin
            acc = acc | leaf[TREE_RADIX * j + k];
          end
        end
      end else begin : g_from_node
        localparam int BASE_IN = lvl_base(l - 1);
        always_comb begin
          acc = '0;
          for (int k = 0; k < FAN; k++) begin
            acc = acc | node[BASE_IN + TREE_RADIX * j + k];
          end
        end
      end

      always_ff @(posedge clk) begin
        node[OUT_IDX] <= acc;
      end
    end
  end

  assign top = node[TOTAL-1];

endmodule
`default_nettype wire

// ===== rtl/indexed_list_store_unit.sv =====
`default_nettype none
// Indexed list store: an ordered list of up to CAPACITY signed 32-bit values
// held in a chain of cells, one value per cell. Each input word carries one
// operation: read at a position, insert at the head, append at the tail,
// insert before a position, or delete at a position; each returns exactly
// one output word with the read value, a found flag and a status (done,
// position out of range, list full). Inserts and deletes are done in the
// cycle the word is accepted: every cell compares the broadcast position
// with its own index and either keeps its value, loads the new value, or
// takes its left or right neighbor's value. Non-read operations and
// out-of-range reads therefore are answered directly and can follow one
// another back to back as long as the output side takes its words. An
// in-range read gathers the selected cell's value through a registered
// OR tree of radix 8, so it occupies the block until the value has passed
// all LEVELS = ceil(log8(CAPACITY)) tree levels and the output is free.
// Only one operation is in flight at a time; the output register lets the
// next word be accepted in the same cycle the previous result is taken.
// Contents of cells that were never written are undefined, but they are
// never returned since reads are limited to positions below the length.
module indexed_list_store_unit
  import ils_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // Fields from bit 0: mode[2:0], position[10:3], item_value[42:11], zero pad.
  input  wire logic [47:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // Fields from bit 0: read_value[31:0], found[32], status[34:33], zero pad.
  output logic [39:0]      m_tdata
);

  localparam int LW     = $clog2(CAPACITY + 1);
  localparam int LEVELS = tree_levels(CAPACITY);
  localparam int CW     = $clog2(LEVELS + 1);

  localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

  // Input word fields.
  mode_t              in_mode;
  logic [7:0]         in_pos;
  logic [VALUE_W-1:0] in_value;

  assign in_mode  = mode_t'(s_tdata[2:0]);
  assign in_pos   = s_tdata[10:3];
  assign in_value = s_tdata[42:11];

  // Control state.
  state_t           state;
  state_t           state_next;
  logic [LW-1:0]    length;
  logic [LW-1:0]    length_next;
  logic [CW-1:0]    cnt;
  logic [CW-1:0]    cnt_next;
  logic [POS_W-1:0] rd_pos;
  logic [POS_W-1:0] rd_pos_next;

  // Output register.
  logic               out_valid_next;
  logic [VALUE_W-1:0] out_value;
  logic [VALUE_W-1:0] out_value_next;
  logic               out_found;
  logic               out_found_next;
  status_t            out_status;
  status_t            out_status_next;

  ils_cmd_t           cmd;
  logic [VALUE_W-1:0] cell_value [CAPACITY];
  logic [VALUE_W-1:0] cell_leaf  [CAPACITY];
  logic [VALUE_W-1:0] tree_top;

  logic             out_free;
  logic             accept;
  logic [POS_W-1:0] pos_w;
  logic [POS_W-1:0] len_w;
  logic             is_full;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign pos_w    = POS_W'(in_pos);
  assign len_w    = POS_W'(length);
  assign is_full  = (len_w == CAP_POS);

  always_comb begin
    state_next      = state;
    length_next     = length;
    cnt_next        = cnt;
    rd_pos_next     = rd_pos;
    out_valid_next  = m_tvalid && !m_tready;
    out_value_next  = out_value;
    out_found_next  = out_found;
    out_status_next = out_status;
    cmd.ins         = 1'b0;
    cmd.del         = 1'b0;
    cmd.pos         = '0;
    cmd.rd_pos      = rd_pos;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          // Most operations answer right away with a zero value.
          out_valid_next  = 1'b1;
          out_value_next  = '0;
          out_found_next  = 1'b0;
          out_status_next = STAT_DONE;
          case (in_mode)
            MODE_READ: begin
              if (pos_w < len_w) begin
                // The answer comes later from the read-out tree.
                out_valid_next = 1'b0;
                rd_pos_next    = pos_w;
                cnt_next       = CW'(LEVELS);
                state_next     = ST_READ;
              end else begin
                out_status_next = STAT_RANGE;
              end
            end
            MODE_HEAD: begin
              if (is_full) begin
                out_status_next = STAT_FULL;
              end else begin
                cmd.ins     = 1'b1;
                cmd.pos     = '0;
                length_next = length + LW'(1);
              end
            end
            MODE_TAIL: begin
              if (is_full) begin
                out_status_next = STAT_FULL;
              end else begin
                cmd.ins     = 1'b1;
                cmd.pos     = len_w;
                length_next = length + LW'(1);
              end
            end
            MODE_AT: begin
              // The range check comes before the full check.
              if (pos_w > len_w) begin
                out_status_next = STAT_RANGE;
              end else if (is_full) begin
                out_status_next = STAT_FULL;
              end else begin
                cmd.ins     = 1'b1;
                cmd.pos     = pos_w;
                length_next = length + LW'(1);
              end
            end
            MODE_DELETE: begin
              if (pos_w < len_w) begin
                cmd.del     = 1'b1;
                cmd.pos     = pos_w;
                length_next = length - LW'(1);
              end else begin
                out_status_next = STAT_RANGE;
              end
            end
            default: begin
              out_status_next = STAT_RANGE;
            end
          endcase
        end
      end
      ST_READ: begin
        if (cnt != '0) begin
          cnt_next = cnt - CW'(1);
        end else if (out_free) begin
          out_valid_next  = 1'b1;
          out_value_next  = tree_top;
          out_found_next  = 1'b1;
          out_status_next = STAT_DONE;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      length   <= '0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      length   <= length_next;
      cnt      <= cnt_next;
      m_tvalid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_pos     <= rd_pos_next;
    out_value  <= out_value_next;
    out_found  <= out_found_next;
    out_status <= out_status_next;
  end

  // The chain of cells. The first cell sees the new value as its missing left
  // neighbor but never loads it; the last sees zero and loads it on every delete.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] left_value;
    logic [VALUE_W-1:0] right_value;

    if (i == 0) begin : g_first
      assign left_value = in_value;
    end else begin : g_mid_l
      assign left_value = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_mid_r
      assign right_value = cell_value[i+1];
    end

    ils_cell #(
      .IDX (i)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .ins_value   (in_value),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (cell_value[i]),
      .leaf        (cell_leaf[i])
    );
  end

  ils_or_tree #(
    .N (CAPACITY)
  ) u_tree (
    .clk  (clk),
    .leaf (cell_leaf),
    .top  (tree_top)
  );

  assign m_tdata = {5'b0, out_status, out_found, out_value};

endmodule
`default_nettype wire
